[sv/hmt_pkg.sv]
// Shared constants and control/status types for the histogram median threshold block.
package hmt_pkg;

    localparam int BINS   = 256;
    localparam int BIN_W  = 8;
    localparam int RES_W  = 9;
    localparam int IN_W   = 8;
    localparam int OUT_W  = 16;

    localparam logic [RES_W-1:0] RES_EMPTY = RES_W'(BINS);

    typedef struct packed {
        logic ready;
        logic clr_wr;
        logic start_scan;
        logic scan_rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic addr_last;
        logic last_acc;
        logic out_busy;
    } t_sts;

endpackage

[sv/hmt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/hmt_ctrl.sv]
// Controller: memory clear after reset, pixel intake, end-of-frame scan and result hand-off.
module hmt_ctrl
    import hmt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_RUN,
        S_DRAIN,
        S_SCAN,
        S_TAIL,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.addr_last) n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.ready = 1'b1;
                if (i_sts.last_acc) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                // last pixel's bin is written back during this cycle
                o_cmd.start_scan = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.addr_last) n_state = S_TAIL;
            end
            S_TAIL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_RUN;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/hmt_dp.sv]
// Datapath: histogram memory with read-modify-write, pixel count, scan accumulator, output word.
module hmt_dp
    import hmt_pkg::*;
#(
    parameter int CNT_W = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_s_tvalid,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_s_tlast,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int SUM_W = CNT_W + BIN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic             accept;
    logic [BIN_W-1:0] pixel;

    logic             r_s1_valid;
    logic [BIN_W-1:0] r_s1_addr;
    logic             r_byp_valid;
    logic [BIN_W-1:0] r_byp_addr;
    logic [CNT_W-1:0] r_byp_data;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] inc;

    logic             ram_we;
    logic [BIN_W-1:0] ram_waddr;
    logic [CNT_W-1:0] ram_wdata;
    logic [BIN_W-1:0] ram_raddr;
    logic [CNT_W-1:0] ram_rdata;

    logic [BIN_W-1:0] r_addr;
    logic             r_acc_valid;
    logic [BIN_W-1:0] r_acc_idx;
    logic [CNT_W-1:0] r_pix_cnt;
    logic [CNT_W-1:0] r_half;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic             r_found;
    logic [RES_W-1:0] r_result;

    logic             r_out_valid;
    logic [RES_W-1:0] r_out_data;

    assign pixel  = i_s_tdata[BIN_W-1:0];
    assign accept = i_s_tvalid & i_cmd.ready;

    // back-to-back hits on one bin read the memory before the earlier write lands
    assign cur = (r_byp_valid && (r_byp_addr == r_s1_addr)) ? r_byp_data : ram_rdata;
    assign inc = (cur == CNT_MAX) ? cur : cur + CNT_W'(1);

    assign ram_we    = r_s1_valid | i_cmd.clr_wr | i_cmd.scan_rd;
    assign ram_waddr = r_s1_valid ? r_s1_addr : r_addr;
    assign ram_wdata = r_s1_valid ? inc : '0;
    assign ram_raddr = i_cmd.scan_rd ? r_addr : pixel;

    hmt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign n_sum = r_sum + SUM_W'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_byp_valid <= 1'b0;
            r_addr      <= '0;
            r_acc_valid <= 1'b0;
            r_pix_cnt   <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= accept;
            r_byp_valid <= r_s1_valid;
            r_acc_valid <= i_cmd.scan_rd;

            if (i_cmd.clr_wr || i_cmd.scan_rd) begin
                r_addr <= r_addr + BIN_W'(1);
            end

            if (i_cmd.start_scan) begin
                r_pix_cnt <= '0;
            end else if (accept && (r_pix_cnt != CNT_MAX)) begin
                r_pix_cnt <= r_pix_cnt + CNT_W'(1);
            end

            if (i_cmd.start_scan) begin
                r_found <= 1'b0;
            end else if (r_acc_valid && !r_found && (n_sum > SUM_W'(r_half))) begin
                r_found <= 1'b1;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= pixel;
        r_byp_addr <= r_s1_addr;
        r_byp_data <= inc;
        r_acc_idx  <= r_addr;
        if (i_cmd.start_scan) begin
            r_half <= r_pix_cnt >> 1;
            r_sum  <= '0;
        end else if (r_acc_valid && !r_found) begin
            r_sum <= n_sum;
            if (n_sum > SUM_W'(r_half)) begin
                r_result <= {1'b0, r_acc_idx} + RES_W'(1);
            end
        end
        if (i_cmd.emit) begin
            r_out_data <= r_found ? r_result : RES_EMPTY;
        end
    end

    assign o_sts.addr_last = (r_addr == '1);
    assign o_sts.last_acc  = accept & i_s_tlast;
    assign o_sts.out_busy  = r_out_valid & ~i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_data);

endmodule

[sv/histogram_median_threshold.sv]
// Histogram median threshold: top level joining controller and datapath.
// Pixels enter at one word per cycle while a frame is open. After the word
// with tlast the input is held off through the drain, scan, tail and emit
// states: the last bin write-back, a pass that reads and zeroes every bin of
// the single write port histogram memory, the final add, and the load of the
// output register, which waits while an earlier result is still untaken.
// After reset a clear pass zeroes the memory before the first pixel is
// taken. Bin and pixel counts saturate at 2^(MAX_PIXELS_LOG2+1)-1; the
// result is 1..256, with 256 when the running sum never passes half the
// pixel count.
module histogram_median_threshold
    import hmt_pkg::*;
#(
    parameter int MAX_PIXELS_LOG2 = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // [7:0] pixel
    input  logic             i_s_tlast,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // [8:0] median_threshold, rest zero
);

    localparam int CNT_W = MAX_PIXELS_LOG2 + 1;

    t_cmd cmd;
    t_sts sts;

    hmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hmt_dp #(
        .CNT_W (CNT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    assign o_s_tready = cmd.ready;

    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sts.out_busy && cmd.emit))
        else $error("result loaded over an untaken word");

    a_no_intake_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.scan_rd || cmd.clr_wr || cmd.start_scan) |-> !o_s_tready)
        else $error("pixel intake during sweep");

    a_last_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.last_acc |=> cmd.start_scan)
        else $error("frame end did not start the scan");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata <= OUT_W'(BINS)))
        else $error("threshold out of range");

endmodule

[tb/sv/tb_histogram_median_threshold.sv]
// Self-checking testbench for the histogram median threshold block: directed and random frames.
`timescale 1ns / 100ps

module tb_histogram_median_threshold;
    import hmt_pkg::*;

    // narrow counters so that bin and pixel count saturation is reachable in a short run
    localparam int CNT_LOG2     = 8;
    localparam int CNT_W        = CNT_LOG2 + 1;
    localparam int RANDOM_WORDS = 830;
    localparam int PHASE_FRAMES = 6;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int N_DIR        = 21;

    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    typedef enum int {
        FILL_UNIFORM,
        FILL_CLUSTER,
        FILL_EXTREME,
        FILL_DOMINANT
    } t_fill;

    typedef struct packed {
        logic [IN_W-1:0]  px;
        logic             lst;
        logic             known;
        logic [RES_W-1:0] thr;
    } t_row;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata  = '0;   // [7:0] pixel
    logic             i_s_tlast  = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;         // [8:0] median_threshold, rest zero

    logic [CNT_W-1:0] hist_model [BINS];
    logic [CNT_W-1:0] frame_pixels;
    logic [RES_W-1:0] thresholds_due [$];

    int n_errors      = 0;
    int n_words       = 0;
    int n_frames      = 0;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;

    // single-pixel frames, two-pixel extremes, a tie at half, and one frame left to the predictor
    t_row dir_rows [N_DIR] = '{
        '{8'h00, 1'b1, 1'b1, 9'd1},
        '{8'hFF, 1'b1, 1'b1, 9'd256},
        '{8'h80, 1'b1, 1'b1, 9'd129},
        '{8'h00, 1'b0, 1'b0, 9'd0},
        '{8'hFF, 1'b1, 1'b1, 9'd256},
        '{8'hFF, 1'b0, 1'b0, 9'd0},
        '{8'h00, 1'b1, 1'b1, 9'd256},
        '{8'h0A, 1'b0, 1'b0, 9'd0},
        '{8'h0A, 1'b0, 1'b0, 9'd0},
        '{8'h14, 1'b1, 1'b1, 9'd11},
        '{8'h55, 1'b0, 1'b0, 9'd0},
        '{8'hAA, 1'b1, 1'b1, 9'd171},
        '{8'h01, 1'b0, 1'b0, 9'd0},
        '{8'h02, 1'b0, 1'b0, 9'd0},
        '{8'h03, 1'b0, 1'b0, 9'd0},
        '{8'h04, 1'b1, 1'b1, 9'd4},
        '{8'h07, 1'b0, 1'b0, 9'd0},
        '{8'h07, 1'b0, 1'b0, 9'd0},
        '{8'hC8, 1'b0, 1'b0, 9'd0},
        '{8'hC8, 1'b0, 1'b0, 9'd0},
        '{8'h07, 1'b1, 1'b0, 9'd0}
    };

    histogram_median_threshold #(
        .MAX_PIXELS_LOG2(CNT_LOG2)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // adds one pixel to the histogram; on the frame's last pixel scans for the median
    task automatic tally_pixel(input logic [IN_W-1:0] px, input logic lst,
                               output logic [RES_W-1:0] thr);
        int unsigned run_sum;
        int unsigned half;
        int unsigned bin;
        run_sum = 0;
        bin = 0;
        thr = '0;
        if (hist_model[px] != CNT_SAT) begin
            hist_model[px] = hist_model[px] + CNT_W'(1);
        end
        if (frame_pixels != CNT_SAT) begin
            frame_pixels = frame_pixels + CNT_W'(1);
        end
        if (lst) begin
            half = 32'(frame_pixels >> 1);
            while (bin < BINS && run_sum <= half) begin
                run_sum += 32'(hist_model[BIN_W'(bin)]);
                bin++;
            end
            thr = RES_W'(bin);
            for (int b = 0; b < BINS; b++) begin
                hist_model[BIN_W'(b)] = '0;
            end
            frame_pixels = '0;
        end
    endtask

    task automatic send_pixel(input logic [IN_W-1:0] px, input logic lst,
                              input logic known, input logic [RES_W-1:0] typed_thr);
        logic [RES_W-1:0] thr;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        i_s_tlast  <= lst;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        tally_pixel(px, lst, thr);
        n_words++;
        if (lst) begin
            thresholds_due.push_back(known ? typed_thr : thr);
            n_frames++;
        end
    endtask

    task automatic send_frame(input int len, input t_fill fill);
        logic [IN_W-1:0] base;
        logic [IN_W-1:0] px;
        base = IN_W'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_UNIFORM:  px = IN_W'($urandom_range(0, 255));
                FILL_CLUSTER:  px = base + IN_W'($urandom_range(0, 7));
                FILL_EXTREME:  px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:       px = ($urandom_range(0, 15) == 0) ? IN_W'($urandom) : base;
            endcase
            send_pixel(px, i == len - 1, 1'b0, '0);
        end
    endtask

    // hold the sender off until every pending threshold has been taken
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (thresholds_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (thresholds_due.size() == 0) begin
                $display("%0t: unexpected threshold word, expected none, got %0d",
                         $time, o_m_tdata);
                n_errors++;
            end else begin
                if (o_m_tdata !== OUT_W'(thresholds_due[0])) begin
                    $display("%0t: threshold mismatch, expected %0d, got %0d",
                             $time, thresholds_due[0], o_m_tdata);
                    n_errors++;
                end
                void'(thresholds_due.pop_front());
            end
        end
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int    len;
        t_fill fill;
        for (int b = 0; b < BINS; b++) begin
            hist_model[BIN_W'(b)] = '0;
        end
        frame_pixels = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_pixel(dir_rows[r].px, dir_rows[r].lst, dir_rows[r].known, dir_rows[r].thr);
        end
        drain_results();

        n_words  = 0;
        n_frames = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            // one long frame drives a bin and the pixel count into saturation
            if (ph == 0) begin
                send_frame($urandom_range(560, 600), FILL_DOMINANT);
            end
            while (n_words < (ph + 1) * RANDOM_WORDS / 4 ||
                   n_frames < (ph + 1) * PHASE_FRAMES) begin
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(1, 16);
                fill = t_fill'($urandom_range(0, 3));
                send_frame(len, fill);
            end
            drain_results();
        end

        repeat (300) @(posedge i_clk);
        if (n_errors == 0 && thresholds_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
sv/hmt_pkg.sv
sv/hmt_ram.sv
sv/hmt_ctrl.sv
sv/hmt_dp.sv
sv/histogram_median_threshold.sv
tb/sv/tb_histogram_median_threshold.sv
